### sv/assert_macros.svh
// Assertion macros used by the checker module of this project.
// Depends on nothing; the including module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/cks_pkg.sv
// Package for the ChaCha key and nonce setup block: types, constants, modes.
// Depends on nothing; used by every module of the block.
package cks_pkg;

  localparam int DOUBLE_ROUNDS_DEFAULT = 10;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam int IN_WIDTH  = 448;
  localparam int OUT_WIDTH = 352;

  typedef enum logic [1:0] {
    MODE_NONCE8  = 2'd0,
    MODE_IETF    = 2'd1,
    MODE_XCHACHA = 2'd2,
    MODE_RSVD    = 2'd3
  } nonce_mode_t;

  // Data carried from cell to cell. The words are only rounded when xmode is set.
  typedef struct packed {
    logic              xmode;
    logic [15:0][31:0] w;
    logic [63:0]       iv;
    logic [31:0]       ctr;
  } cell_t;

endpackage

### sv/cks_cell.sv
// One cell of the round chain: half of a column or diagonal round on all four lanes, applied only when xmode is set.
// Depends on cks_pkg for cell_t.
module cks_cell
  import cks_pkg::*;
#(
  parameter bit DIAG = 1'b0,
  parameter bit SECOND = 1'b0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  cell_t in_data,
  output logic  out_valid,
  output cell_t out_data
);

  localparam int ROT_A = SECOND ? 8 : 16;
  localparam int ROT_B = SECOND ? 7 : 12;

  logic [15:0][31:0] w_next;

  always_comb begin
    w_next = in_data.w;
  end

  logic [15:0][31:0] w_calc;

  genvar i;
  generate
    for (i = 0; i < 4; i++) begin : g_lane
      localparam int IA = i;
      localparam int IB = 4 + ((i + (DIAG ? 1 : 0)) % 4);
      localparam int IC = 8 + ((i + (DIAG ? 2 : 0)) % 4);
      localparam int ID = 12 + ((i + (DIAG ? 3 : 0)) % 4);
      logic [31:0] a_sum, d_mix, d_rot, c_sum, b_mix, b_rot;
      always_comb begin
        a_sum = in_data.w[IA] + in_data.w[IB];
        d_mix = in_data.w[ID] ^ a_sum;
        d_rot = (d_mix << ROT_A) | (d_mix >> (32 - ROT_A));
        c_sum = in_data.w[IC] + d_rot;
        b_mix = in_data.w[IB] ^ c_sum;
        b_rot = (b_mix << ROT_B) | (b_mix >> (32 - ROT_B));
      end
      assign w_calc[IA] = a_sum;
      assign w_calc[IB] = b_rot;
      assign w_calc[IC] = c_sum;
      assign w_calc[ID] = d_rot;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.xmode <= in_data.xmode;
      out_data.iv    <= in_data.iv;
      out_data.ctr   <= in_data.ctr;
      out_data.w     <= in_data.xmode ? w_calc : w_next;
    end
  end

endmodule

### sv/cks_out.sv
// Result packing, output register and skid stage of the key setup block.
// Depends on cks_pkg for cell_t and the output width.
module cks_out
  import cks_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  cell_t                in_data,
  output logic                 advance,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_WIDTH-1:0] m_axis_tdata
);

  logic [OUT_WIDTH-1:0] result;
  logic [OUT_WIDTH-1:0] skid_data;
  logic                 skid_valid;
  logic [63:0]          k0, k1, k2, k3;

  always_comb begin
    if (in_data.xmode) begin
      k0 = {in_data.w[1], in_data.w[0]};
      k1 = {in_data.w[3], in_data.w[2]};
      k2 = {in_data.w[13], in_data.w[12]};
      k3 = {in_data.w[15], in_data.w[14]};
    end else begin
      k0 = {in_data.w[5], in_data.w[4]};
      k1 = {in_data.w[7], in_data.w[6]};
      k2 = {in_data.w[9], in_data.w[8]};
      k3 = {in_data.w[11], in_data.w[10]};
    end
    result = {in_data.ctr, in_data.iv, k3, k2, k1, k0};
  end

  assign advance = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (skid_valid) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end
    end else if (in_valid) begin
      if (m_axis_tvalid && !m_axis_tready) begin
        skid_valid <= 1'b1;
      end else begin
        m_axis_tvalid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tdata <= skid_data;
      end
    end else if (in_valid) begin
      if (m_axis_tvalid && !m_axis_tready) begin
        skid_data <= result;
      end else begin
        m_axis_tdata <= result;
      end
    end
  end

endmodule

### sv/chacha_key_nonce_setup.sv
// Chain of 4*DOUBLE_ROUNDS round cells, then the output register.
// Throughput: one transaction per cycle while the output is not stalled.
// Each cell does half of a column or diagonal round; the skid stage absorbs one stall.
// Reset (rst, synchronous) empties the chain and sets nonce_mode to the 8-byte mode.
// Depends on cks_pkg, cks_cell and cks_out.
module chacha_key_nonce_setup
  import cks_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data,      // nonce_mode
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // key_0, key_1, key_2, key_3, nonce_a, nonce_b, nonce_c (64 bits each)
  input  logic [IN_WIDTH-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // state_key_0..state_key_3, state_iv (64 bits each), counter_high (32 bits)
  output logic [OUT_WIDTH-1:0] m_axis_tdata
);

  localparam int NCELLS = 4 * DOUBLE_ROUNDS;

  nonce_mode_t nonce_mode;
  logic        advance;
  logic        chain_valid [NCELLS+1];
  cell_t       chain_data  [NCELLS+1];
  cell_t       entry;
  logic [63:0] key_0, key_1, key_2, key_3, nonce_a, nonce_b, nonce_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nonce_mode <= MODE_NONCE8;
    end else if (cfg_valid && cfg_ready) begin
      nonce_mode <= nonce_mode_t'(cfg_data);
    end
  end

  assign {nonce_c, nonce_b, nonce_a, key_3, key_2, key_1, key_0} = s_axis_tdata;

  always_comb begin
    entry       = '0;
    entry.w[4]  = key_0[31:0];
    entry.w[5]  = key_0[63:32];
    entry.w[6]  = key_1[31:0];
    entry.w[7]  = key_1[63:32];
    entry.w[8]  = key_2[31:0];
    entry.w[9]  = key_2[63:32];
    entry.w[10] = key_3[31:0];
    entry.w[11] = key_3[63:32];
    unique case (nonce_mode) inside
      MODE_NONCE8: begin
        entry.iv = nonce_a;
      end
      MODE_IETF: begin
        entry.iv  = {nonce_b[31:0], nonce_a[63:32]};
        entry.ctr = nonce_a[31:0];
      end
      MODE_XCHACHA, MODE_RSVD: begin
        entry.xmode = 1'b1;
        entry.w[0]  = SIGMA0;
        entry.w[1]  = SIGMA1;
        entry.w[2]  = SIGMA2;
        entry.w[3]  = SIGMA3;
        entry.w[12] = nonce_a[31:0];
        entry.w[13] = nonce_a[63:32];
        entry.w[14] = nonce_b[31:0];
        entry.w[15] = nonce_b[63:32];
        entry.iv    = nonce_c;
      end
      default: begin
        entry.iv = nonce_a;
      end
    endcase
  end

  assign s_axis_tready  = advance;
  assign chain_valid[0] = s_axis_tvalid && s_axis_tready;
  assign chain_data[0]  = entry;

  genvar k;
  generate
    for (k = 0; k < NCELLS; k++) begin : g_cell
      cks_cell #(
        .DIAG   (((k / 2) % 2) == 1),
        .SECOND ((k % 2) == 1)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (advance),
        .in_valid  (chain_valid[k]),
        .in_data   (chain_data[k]),
        .out_valid (chain_valid[k+1]),
        .out_data  (chain_data[k+1])
      );
    end
  endgenerate

  cks_out u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (chain_valid[NCELLS] && advance),
    .in_data       (chain_data[NCELLS]),
    .advance       (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### sv/cks_checker.sv
// Port-level checks for chacha_key_nonce_setup, bound to the top level.
// Depends on assert_macros.svh and cks_pkg.
`include "assert_macros.svh"

module cks_checker
  import cks_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_WIDTH-1:0] m_axis_tdata
);

  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "Stalled result transaction changed.")
  `ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_axis_tvalid && s_axis_tready, "Block not empty after reset.")
  `ASSERT_CLK(a_stall_cause, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready), "Input stalled without an output stall.")
  `ASSERT_CLK(a_skid_drain, m_axis_tvalid && m_axis_tready && !s_axis_tready |=> m_axis_tvalid && s_axis_tready, "Held result not moved to the output.")

endmodule

bind chacha_key_nonce_setup cks_checker u_cks_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### sim/testbench.sv
// Self-checking testbench for chacha_key_nonce_setup: streams key and nonce requests
// through the block in every nonce mode and checks each cipher state result.
// Depends on cks_pkg and the chacha_key_nonce_setup RTL.
`timescale 1ns / 100ps

module testbench;
  import cks_pkg::*;

  localparam int ROUNDS = DOUBLE_ROUNDS_DEFAULT;
  localparam int LATENCY = 4 * ROUNDS;
  localparam int PHASE_ITEMS = 190;
  localparam int PHASES = 10;
  localparam int HOLD_CYCLES = 160;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic [63:0] key [4];
    logic [63:0] nonce_a;
    logic [63:0] nonce_b;
    logic [63:0] nonce_c;
  } setup_request_t;

  typedef struct {
    logic [63:0] state_key [4];
    logic [63:0] state_iv;
    logic [31:0] counter_high;
  } cipher_state_t;

  class cipher_state_scoreboard;
    nonce_mode_t   mode;
    cipher_state_t expected_states[$];
    int            errors;

    function new();
      mode = MODE_NONCE8;
      errors = 0;
    endfunction

    static function logic [127:0] quarter(logic [31:0] a, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
      a += b; d ^= a; d = {d[15:0], d[31:16]};
      c += d; b ^= c; b = {b[19:0], b[31:20]};
      a += b; d ^= a; d = {d[23:0], d[31:24]};
      c += d; b ^= c; b = {b[24:0], b[31:25]};
      return {a, b, c, d};
    endfunction

    function cipher_state_t predict_state(setup_request_t req);
      cipher_state_t st;
      logic [31:0]   w [16];
      for (int i = 0; i < 4; i++) st.state_key[i] = req.key[i];
      st.counter_high = '0;
      case (mode)
        MODE_NONCE8: begin
          st.state_iv = req.nonce_a;
        end
        MODE_IETF: begin
          st.state_iv = {req.nonce_b[31:0], req.nonce_a[63:32]};
          st.counter_high = req.nonce_a[31:0];
        end
        default: begin
          // The reserved mode value behaves as XChaCha.
          w[0] = SIGMA0; w[1] = SIGMA1; w[2] = SIGMA2; w[3] = SIGMA3;
          for (int i = 0; i < 4; i++) begin
            w[4 + 2 * i] = req.key[i][31:0];
            w[5 + 2 * i] = req.key[i][63:32];
          end
          w[12] = req.nonce_a[31:0]; w[13] = req.nonce_a[63:32];
          w[14] = req.nonce_b[31:0]; w[15] = req.nonce_b[63:32];
          for (int r = 0; r < ROUNDS; r++) begin
            {w[0], w[4], w[8], w[12]} = quarter(w[0], w[4], w[8], w[12]);
            {w[1], w[5], w[9], w[13]} = quarter(w[1], w[5], w[9], w[13]);
            {w[2], w[6], w[10], w[14]} = quarter(w[2], w[6], w[10], w[14]);
            {w[3], w[7], w[11], w[15]} = quarter(w[3], w[7], w[11], w[15]);
            {w[0], w[5], w[10], w[15]} = quarter(w[0], w[5], w[10], w[15]);
            {w[1], w[6], w[11], w[12]} = quarter(w[1], w[6], w[11], w[12]);
            {w[2], w[7], w[8], w[13]} = quarter(w[2], w[7], w[8], w[13]);
            {w[3], w[4], w[9], w[14]} = quarter(w[3], w[4], w[9], w[14]);
          end
          st.state_key[0] = {w[1], w[0]};
          st.state_key[1] = {w[3], w[2]};
          st.state_key[2] = {w[13], w[12]};
          st.state_key[3] = {w[15], w[14]};
          st.state_iv = req.nonce_c;
        end
      endcase
      return st;
    endfunction

    function void note_request(setup_request_t req);
      expected_states.push_back(predict_state(req));
    endfunction

    function void check_state(logic [OUT_WIDTH-1:0] data);
      cipher_state_t exp_st;
      logic [63:0]   exp_f [6];
      logic [63:0]   act_f [6];
      string         names [6];
      if (expected_states.size() == 0) begin
        $error("Result transaction arrived with no expected state pending");
        errors++;
        return;
      end
      exp_st = expected_states.pop_front();
      names = '{"state_key_0", "state_key_1", "state_key_2", "state_key_3",
                "state_iv", "counter_high"};
      for (int i = 0; i < 4; i++) exp_f[i] = exp_st.state_key[i];
      exp_f[4] = exp_st.state_iv;
      exp_f[5] = {32'd0, exp_st.counter_high};
      for (int i = 0; i < 5; i++) act_f[i] = data[64 * i +: 64];
      act_f[5] = {32'd0, data[320 +: 32]};
      for (int i = 0; i < 6; i++) begin
        if (act_f[i] !== exp_f[i]) begin
          $error("%s mismatch: expected %h, actual %h", names[i], exp_f[i], act_f[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_WIDTH-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_WIDTH-1:0] m_axis_tdata;

  cipher_state_scoreboard board;
  bit source_gaps;
  bit sink_stalls;
  bit sink_hold;
  int idle_cycles;

  chacha_key_nonce_setup #(
    .DOUBLE_ROUNDS(ROUNDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) board.check_state(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: ready in random runs, random stall bursts, and one long hold.
  initial begin
    @(negedge clk);
    forever begin
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic setup_request_t random_request();
    setup_request_t req;
    for (int i = 0; i < 4; i++) req.key[i] = random_word();
    req.nonce_a = random_word();
    req.nonce_b = random_word();
    req.nonce_c = random_word();
    return req;
  endfunction

  function automatic setup_request_t pattern_request(int kind);
    setup_request_t req;
    logic [63:0]    f [7];
    for (int i = 0; i < 7; i++) begin
      case (kind)
        0: f[i] = '0;
        1: f[i] = '1;
        2: f[i] = {32{2'b01}};
        3: f[i] = {32{2'b10}};
        default: f[i] = 64'h0706050403020100 + i * 64'h0808080808080808;
      endcase
    end
    for (int i = 0; i < 4; i++) req.key[i] = f[i];
    req.nonce_a = f[4];
    req.nonce_b = f[5];
    req.nonce_c = f[6];
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(setup_request_t req);
    if (source_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {req.nonce_c, req.nonce_b, req.nonce_a,
                     req.key[3], req.key[2], req.key[1], req.key[0]};
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(req);
    @(negedge clk);
  endtask

  task automatic write_mode(nonce_mode_t mode);
    s_axis_tvalid <= 1'b0;
    while (board.expected_states.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    board.mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    nonce_mode_t phase_modes [PHASES];
    board = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    sink_hold = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The 8-byte mode is the reset setting, so it runs without a write.
    for (int m = 0; m < 4; m++) begin
      if (m != 0) write_mode(nonce_mode_t'(m));
      for (int k = 0; k < 5; k++) send_request(pattern_request(k));
    end

    phase_modes[0] = MODE_XCHACHA;
    phase_modes[1] = MODE_NONCE8;
    phase_modes[2] = MODE_RSVD;
    phase_modes[3] = MODE_IETF;
    for (int p = 4; p < PHASES; p++) phase_modes[p] = nonce_mode_t'($urandom_range(0, 3));

    for (int p = 0; p < PHASES; p++) begin
      write_mode(phase_modes[p]);
      // The first phase keeps the source busy while the sink holds off.
      source_gaps = (p != 0 && p != PHASES - 1);
      sink_stalls = (p != PHASES - 1);
      if (p == 0) sink_hold = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
    end
    s_axis_tvalid <= 1'b0;

    while (board.expected_states.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    if (board.errors == 0 && board.expected_states.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
